### rtl/core/bmd_pkg.sv
// Package for the bracketed message deframer.
// Holds widths, framing characters, default parameter values and the result type.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bmd_pkg;

  localparam int BYTE_W = 8;
  localparam int PID_W  = 24;
  localparam int LEN_W  = 14;

  localparam int HEADER_BYTES_DEF  = 16;
  localparam int PID_CHARS_DEF     = 7;
  localparam int LENGTH_DIGITS_DEF = 4;

  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic              valid;
    logic [PID_W-1:0]  sender_pid;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
  } bmd_result_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

### rtl/core/bmd_ifs.sv
// Channel interfaces of the bracketed message deframer: byte input and result output.
// Each carries valid, ready and the payload; depends on bmd_pkg for widths.
`default_nettype none

interface bmd_in_if;
  import bmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bmd_out_if;
  import bmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  sender_pid;
  logic [BYTE_W-1:0] payload_byte;
  logic              last;

  modport source (output valid, output sender_pid, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input sender_pid, input payload_byte, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/bmd_core.sv
// Frame parsing state of the deframer: hunt, header field parse and payload counting.
// Produces at most one result per accepted byte; depends on bmd_pkg.
`default_nettype none

module bmd_core #(
  parameter int HEADER_BYTES  = bmd_pkg::HEADER_BYTES_DEF,
  parameter int PID_CHARS     = bmd_pkg::PID_CHARS_DEF,
  parameter int LENGTH_DIGITS = bmd_pkg::LENGTH_DIGITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [bmd_pkg::BYTE_W-1:0]  data_in,
  output bmd_pkg::bmd_result_t             res
);
  import bmd_pkg::*;

  localparam int HCW = $clog2(HEADER_BYTES + 1);
  localparam int LDW = $clog2(LENGTH_DIGITS + 1);

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD} phase_t;
  typedef enum logic [1:0] {FP_PID, FP_LEN, FP_DONE} field_t;

  phase_t            phase_r, phase_nxt;
  field_t            field_r, field_nxt;
  logic [HCW-1:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic              pid_open_r, pid_open_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LDW-1:0]    len_dig_r, len_dig_nxt;
  logic [LEN_W-1:0]  pay_cnt_r, pay_cnt_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic              stopped_r, stopped_nxt;

  logic              digit;
  logic [PID_W-1:0]  pid_x10;
  logic [LEN_W-1:0]  len_x10;
  logic              start_pay;

  assign digit   = is_digit(data_in);
  assign pid_x10 = {pid_r[PID_W-4:0], 3'b000} + {pid_r[PID_W-2:0], 1'b0}
                   + {{(PID_W-4){1'b0}}, data_in[3:0]};
  assign len_x10 = {len_r[LEN_W-4:0], 3'b000} + {len_r[LEN_W-2:0], 1'b0}
                   + {{(LEN_W-4){1'b0}}, data_in[3:0]};

  always_comb begin
    phase_nxt    = phase_r;
    field_nxt    = field_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    pid_nxt      = pid_r;
    pid_open_nxt = pid_open_r;
    len_nxt      = len_r;
    len_dig_nxt  = len_dig_r;
    pay_cnt_nxt  = pay_cnt_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    stopped_nxt  = stopped_r;
    start_pay    = 1'b0;
    res.valid        = 1'b0;
    res.sender_pid   = pid_r;
    res.payload_byte = held_r;
    res.last         = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        if (int'(hdr_cnt_r) >= HEADER_BYTES) begin
          start_pay = 1'b1;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          case (field_r)
            FP_PID: begin
              if (data_in == CH_SLASH) begin
                field_nxt = FP_LEN;
              end else if (int'(hdr_cnt_r) <= PID_CHARS) begin
                if (pid_open_r && digit) begin
                  pid_nxt = pid_x10;
                end else begin
                  pid_open_nxt = 1'b0;
                end
              end
            end
            FP_LEN: begin
              if (digit && (int'(len_dig_r) < LENGTH_DIGITS)) begin
                len_nxt     = len_x10;
                len_dig_nxt = len_dig_r + 1'b1;
              end else begin
                field_nxt = FP_DONE;
              end
            end
            default: begin
            end
          endcase
          if (data_in == CH_COLON) begin
            start_pay = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        if ((pay_cnt_r < len_r) && (data_in != CH_CLOSE)) begin
          pay_cnt_nxt = pay_cnt_r + 1'b1;
          if (!stopped_r) begin
            res.valid    = held_vld_r;
            held_vld_nxt = 1'b0;
            if (data_in == CH_NUL) begin
              stopped_nxt = 1'b1;
              res.last    = 1'b1;
            end else begin
              held_nxt     = data_in;
              held_vld_nxt = 1'b1;
            end
          end
        end else begin
          res.valid    = held_vld_r;
          res.last     = 1'b1;
          held_vld_nxt = 1'b0;
          phase_nxt    = PH_HUNT;
        end
      end
      default: begin
        if (data_in == CH_OPEN) begin
          phase_nxt    = PH_HEADER;
          hdr_cnt_nxt  = HCW'(1);
          field_nxt    = FP_PID;
          pid_nxt      = '0;
          pid_open_nxt = 1'b1;
          len_nxt      = '0;
          len_dig_nxt  = '0;
        end
      end
    endcase

    if (start_pay) begin
      phase_nxt    = PH_PAYLOAD;
      pay_cnt_nxt  = '0;
      held_vld_nxt = 1'b0;
      held_nxt     = '0;
      stopped_nxt  = 1'b0;
    end

    res.valid = res.valid & step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      field_r    <= FP_PID;
      hdr_cnt_r  <= '0;
      pid_r      <= '0;
      pid_open_r <= 1'b1;
      len_r      <= '0;
      len_dig_r  <= '0;
      pay_cnt_r  <= '0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      stopped_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      field_r    <= field_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      pid_r      <= pid_nxt;
      pid_open_r <= pid_open_nxt;
      len_r      <= len_nxt;
      len_dig_r  <= len_dig_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bracketed_message_deframer.sv
// Top level of the bracketed message deframer: parser core and output register.
// Depends on bmd_pkg, the channel interfaces in bmd_ifs and bmd_core.
//
// The block takes one raw byte per input transaction on in_ch and deframes
// messages of the form [pid/len:payload]. Each payload byte before the first
// NUL leaves on out_ch together with the decimal pid of its frame; the final
// byte of a frame carries last. One payload byte is held back inside the
// parser, so a byte appears on out_ch only once the following byte (or the
// end of the frame) has been accepted.
// A byte is accepted in every cycle while the output register is empty or
// being emptied, so the sustained rate is one byte per cycle. A result is
// presented in the cycle after the input transaction that releases it.
// When the receiver stalls with a result waiting, in_ch.ready falls and the
// byte stream is held off; nothing is dropped.
// Reset (rst_n low at a clock edge) returns the parser to hunting for an
// open bracket and empties the output register.
`default_nettype none

module bracketed_message_deframer #(
  parameter int HEADER_BYTES  = bmd_pkg::HEADER_BYTES_DEF,
  parameter int PID_CHARS     = bmd_pkg::PID_CHARS_DEF,
  parameter int LENGTH_DIGITS = bmd_pkg::LENGTH_DIGITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmd_in_if.sink     in_ch,
  bmd_out_if.source  out_ch
);
  import bmd_pkg::*;

  bmd_result_t       res;
  logic              in_fire;
  logic              out_vld_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  bmd_core #(
    .HEADER_BYTES  (HEADER_BYTES),
    .PID_CHARS     (PID_CHARS),
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .data_in (in_ch.in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_pid_r  <= res.sender_pid;
      out_byte_r <= res.payload_byte;
      out_last_r <= res.last;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.sender_pid   = out_pid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

### dv/bracketed_message_deframer_tb.sv
// Self-checking testbench for bracketed_message_deframer: a directed table, then random frames.
// Results are checked in order against a cycle-free predictor of the deframer kept in this file.
// Depends on bmd_pkg, the channel interfaces in bmd_ifs and the RTL of the block.

module bracketed_message_deframer_tb;
  import bmd_pkg::*;

  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 1350;
  localparam int LATE_PART    = 1150;
  localparam int HOLD_AT      = 500;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD} frame_phase_t;
  typedef enum logic [1:0] {FLD_PID, FLD_LEN, FLD_DONE} header_field_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] pbyte;
    logic              last;
  } deframed_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                typed;
    bit                has;
    deframed_t         res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bmd_in_if  in_ch();
  bmd_out_if out_ch();

  bracketed_message_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frame_phase_t      fr_phase  = PH_HUNT;
  logic [4:0]        hdr_count = '0;
  header_field_t     fld       = FLD_PID;
  logic [PID_W-1:0]  pid_acc   = '0;
  logic              pid_open  = 1'b1;
  logic [LEN_W-1:0]  len_acc   = '0;
  logic [2:0]        len_ndig  = '0;
  logic [LEN_W-1:0]  pay_count = '0;
  logic [BYTE_W-1:0] held_b    = '0;
  logic              held_v    = 1'b0;
  logic              muted     = 1'b0;

  deframed_t deframed_q[$];
  logic [BYTE_W-1:0] frame_bytes[$];

  int  n_sent, n_live, n_results, n_bad, n_frames, n_overflow, n_in_stall;
  bit  src_idle_on, sink_idle_on, long_hold_req;

  dir_row_t dir_tab [0:N_DIRECTED-1] = '{
    '{8'h78,    1'b1, 1'b0, '0},
    '{CH_OPEN,  1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{CH_SLASH, 1'b0, 1'b0, '0},
    '{8'h32,    1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, '0},
    '{8'hFF,    1'b0, 1'b0, '0},
    '{CH_NUL,   1'b1, 1'b1, '{24'd9999999, 8'hFF, 1'b1}},
    '{8'h7A,    1'b1, 1'b0, '0},
    '{CH_OPEN,  1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, '0},
    '{8'h71,    1'b1, 1'b0, '0},
    '{CH_OPEN,  1'b0, 1'b0, '0},
    '{8'h31,    1'b0, 1'b0, '0},
    '{CH_SLASH, 1'b0, 1'b0, '0},
    '{8'h39,    1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, '0},
    '{8'h41,    1'b0, 1'b0, '0},
    '{CH_CLOSE, 1'b1, 1'b1, '{24'd1, 8'h41, 1'b1}}
  };

  task automatic enter_payload();
    fr_phase  = PH_PAYLOAD;
    pay_count = '0;
    held_v    = 1'b0;
    held_b    = '0;
    muted     = 1'b0;
  endtask

  task automatic release_held(input logic is_last, output bit got, output deframed_t r);
    got = held_v;
    r   = '{pid_acc, held_b, is_last};
    held_v = 1'b0;
  endtask

  task automatic deframe_step(input logic [BYTE_W-1:0] b, output bit got, output deframed_t r);
    logic [31:0] acc;
    logic [4:0]  pos;
    logic        digit;
    got   = 1'b0;
    r     = '0;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    case (fr_phase)
      PH_HEADER: begin
        if (hdr_count >= HEADER_BYTES_DEF) begin
          enter_payload();
        end else begin
          pos = hdr_count;
          hdr_count = hdr_count + 5'd1;
          if (fld == FLD_PID) begin
            if (b == CH_SLASH) begin
              fld = FLD_LEN;
            end else if (pos <= PID_CHARS_DEF) begin
              if (pid_open && digit) begin
                acc = pid_acc * 10 + (b - CH_ZERO);
                pid_acc = acc[PID_W-1:0];
              end else begin
                pid_open = 1'b0;
              end
            end
          end else if (fld == FLD_LEN) begin
            if (digit && len_ndig < LENGTH_DIGITS_DEF) begin
              acc = len_acc * 10 + (b - CH_ZERO);
              len_acc  = acc[LEN_W-1:0];
              len_ndig = len_ndig + 3'd1;
            end else begin
              fld = FLD_DONE;
            end
          end
          if (b == CH_COLON) enter_payload();
        end
      end
      PH_PAYLOAD: begin
        if (pay_count < len_acc && b != CH_CLOSE) begin
          pay_count = pay_count + 1'b1;
          if (!muted) begin
            if (b == CH_NUL) begin
              muted = 1'b1;
              release_held(1'b1, got, r);
            end else begin
              release_held(1'b0, got, r);
              held_b = b;
              held_v = 1'b1;
            end
          end
        end else begin
          release_held(1'b1, got, r);
          fr_phase = PH_HUNT;
        end
      end
      default: begin
        if (b == CH_OPEN) begin
          fr_phase  = PH_HEADER;
          hdr_count = 5'd1;
          fld       = FLD_PID;
          pid_acc   = '0;
          pid_open  = 1'b1;
          len_acc   = '0;
          len_ndig  = '0;
        end
      end
    endcase
  endtask

  // Offers one byte from a falling edge and returns at the falling edge after its transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input bit t_has,
                           input deframed_t t_res);
    bit        got;
    deframed_t r;
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (fr_phase != PH_HUNT || b == CH_OPEN) n_live++;
    n_sent++;
    deframe_step(b, got, r);
    if (typed) begin
      got = t_has;
      r   = t_res;
    end
    if (got) deframed_q.push_back(r);
    if (n_live == N_DIRECTED + HOLD_AT) long_hold_req = 1'b1;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) n_in_stall++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (deframed_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected result: pid %0d byte %02h last %0b",
                   out_ch.sender_pid, out_ch.payload_byte, out_ch.last);
      end else begin
        if (out_ch.sender_pid !== deframed_q[0].pid
            || out_ch.payload_byte !== deframed_q[0].pbyte
            || out_ch.last !== deframed_q[0].last) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $write("mismatch on result %0d: expected pid %0d byte %02h last %0b",
                   n_results, deframed_q[0].pid, deframed_q[0].pbyte, deframed_q[0].last);
            $display(", got pid %0d byte %02h last %0b",
                     out_ch.sender_pid, out_ch.payload_byte, out_ch.last);
          end
        end
        void'(deframed_q.pop_front());
      end
    end
  end

  // The receiver stalls in short bursts, and once for a long stretch so that the block backs up.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #2400000;
    $display("bracketed_message_deframer_tb: done, errors");
    $finish;
  end

  initial begin
    int kind, npid, nd, lval, plen, mode, i;
    bit late;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    rst_n         = 1'b0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k])
      send_byte(dir_tab[k].b, dir_tab[k].typed, dir_tab[k].has, dir_tab[k].res);

    while (n_live < N_DIRECTED + N_RANDOM) begin
      late         = n_live > N_DIRECTED + LATE_PART;
      src_idle_on  = !late && ($urandom_range(0, 3) != 0);
      sink_idle_on = !late && ($urandom_range(0, 4) != 0);
      frame_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        n_frames++;
        frame_bytes.push_back(CH_OPEN);
        npid = $urandom_range(0, 8);
        for (i = 0; i < npid; i++) frame_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
        lval = 0;
        if ($urandom_range(0, 5) != 0) begin
          frame_bytes.push_back(CH_SLASH);
          nd = $urandom_range(1, 4);
          if ($urandom_range(0, 15) == 0) begin
            nd   = 4;
            lval = $urandom_range(0, 9999);
          end else begin
            lval = (nd == 1) ? $urandom_range(0, 9) : $urandom_range(0, 20);
          end
          for (i = nd - 1; i >= 0; i--)
            frame_bytes.push_back(8'(CH_ZERO + (lval / (10 ** i)) % 10));
          if (nd == 4 && $urandom_range(0, 5) == 0)
            frame_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        frame_bytes.push_back(CH_COLON);
        mode = (lval > 24) ? 1 : $urandom_range(0, 2);
        plen = (mode == 0) ? lval : (mode == 1) ? $urandom_range(0, (lval > 24) ? 24 : lval)
                                                 : $urandom_range(0, 24);
        for (i = 0; i < plen; i++)
          frame_bytes.push_back(($urandom_range(0, 19) == 0) ? CH_NUL
                                                             : 8'($urandom_range(1, 255)));
        frame_bytes.push_back((mode == 1) ? CH_CLOSE : 8'($urandom_range(0, 255)));
      end else if (kind == 7) begin
        // The header runs past its limit without a colon; the byte after it is dropped.
        n_overflow++;
        frame_bytes.push_back(CH_OPEN);
        for (i = 0; i < 3; i++) frame_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        frame_bytes.push_back(CH_SLASH);
        for (i = 0; i < 3; i++) frame_bytes.push_back(CH_ZERO);
        lval = $urandom_range(0, 9);
        frame_bytes.push_back(8'(CH_ZERO + lval));
        while (frame_bytes.size() < HEADER_BYTES_DEF + 1) begin
          i = $urandom_range(0, 255);
          if (8'(i) != CH_COLON) frame_bytes.push_back(8'(i));
        end
        for (i = 0; i < lval + 1; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        plen = $urandom_range(1, 6);
        for (i = 0; i < plen; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      foreach (frame_bytes[k]) send_byte(frame_bytes[k], 1'b0, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d inside frames), %0d framed and %0d header overflow sequences.",
             n_sent, n_live, n_frames, n_overflow);
    $display("Checked %0d payload results; the input was held off for %0d cycles.",
             n_results, n_in_stall);
    if (n_bad == 0 && deframed_q.size() == 0) begin
      $display("bracketed_message_deframer_tb: done, clean");
    end else begin
      $display("%0d mismatches in total", n_bad);
      $display("bracketed_message_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule
